@@ rtl/acji_pkg.sv @@
// Shared types and constants for the affine cell Jacobian inverse block.
package acji_pkg;

    localparam int unsigned RAW_BITS = 32;
    localparam int unsigned DIF_BITS = 34;
    localparam int unsigned PRD_BITS = 68;
    localparam int unsigned COF_BITS = 70;
    localparam int unsigned DET_BITS = 106;
    localparam int unsigned DIV_BITS = 138;
    // Cofactor split for the determinant products: low chunk and operand width
    localparam int unsigned LOW_BITS = 35;
    localparam int unsigned OPD_BITS = 36;

    typedef struct packed {
        logic              is_tetrahedron;
        logic [1:0]        vertex_index;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] inv_00;
        logic signed [31:0] inv_01;
        logic signed [31:0] inv_02;
        logic signed [31:0] inv_10;
        logic signed [31:0] inv_11;
        logic signed [31:0] inv_12;
        logic signed [31:0] inv_20;
        logic signed [31:0] inv_21;
        logic signed [31:0] inv_22;
        logic [47:0]        abs_det;
        logic               singular;
    } t_out_item;

    // One finished cell: edge-vector matrix handed from front to back.
    typedef struct packed {
        logic                          tet;
        logic signed [DIF_BITS-1:0]    f00, f01, f02;
        logic signed [DIF_BITS-1:0]    f10, f11, f12;
        logic signed [DIF_BITS-1:0]    f20, f21, f22;
    } t_cell_job;

    typedef enum logic [2:0] {
        S_IDLE,
        S_COF,
        S_DET,
        S_MAG,
        S_CHK,
        S_DIV,
        S_OUT
    } t_back_state;

endpackage

@@ rtl/affine_cell_jacobian_inverse.sv @@
// Top level of the affine cell Jacobian inverse block.
// Vertices arrive one per transaction; the transaction carrying the last vertex
// (index 2 triangle, 3 tetrahedron) yields one result: the Q16.16 inverse of the
// edge-vector Jacobian, |det| and a singular flag. The front stores vertices and
// forms edge vectors into a registered job; a two-entry queue feeds the back end,
// which forms the cofactors on a multiplier pair, then the determinant one cofactor
// chunk at a time, then |det| and the singular test, then each inverse entry in
// the one-bit-per-cycle divider (skipped when singular). The back end takes no new
// cell until the result of the last one is loaded.
module affine_cell_jacobian_inverse
    import acji_pkg::*;
#(
    parameter int COORD_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_in_item    i_data,
    output logic        o_valid,
    input  logic        i_stall,
    output t_out_item   o_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    logic [15:0] r_thresh;
    logic        w_fv, w_fs, w_qv, w_qs;
    t_cell_job   w_fj, w_qj;

    assign o_cfg_ready = 1'b1;

    // Hold the threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_thresh <= 16'd1;
        else if (i_cfg_valid) r_thresh <= i_cfg_data;
    end

    acji_front #(.COORD_BITS(COORD_BITS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_data(i_data), .o_job_valid(w_fv), .i_job_stall(w_fs), .o_job(w_fj)
    );

    acji_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_fv), .o_stall(w_fs),
        .i_data(w_fj), .o_valid(w_qv), .i_stall(w_qs), .o_data(w_qj)
    );

    acji_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_thresh(r_thresh), .i_valid(w_qv),
        .o_stall(w_qs), .i_job(w_qj), .o_valid(o_valid), .i_stall(i_stall),
        .o_data(o_data)
    );

endmodule

@@ rtl/acji_front.sv @@
// Front end: vertex store and edge-vector matrix formation for each cell.
module acji_front
    import acji_pkg::*;
#(
    parameter int COORD_BITS = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_item  i_data,
    output logic      o_job_valid,
    input  logic      i_job_stall,
    output t_cell_job o_job
);

    localparam int CW = (COORD_BITS < 32) ? COORD_BITS : 32;

    logic signed [CW-1:0] r_sx [4];
    logic signed [CW-1:0] r_sy [4];
    logic signed [CW-1:0] r_sz [4];
    logic                 r_job_valid;
    t_cell_job            r_job;
    logic                 w_acc;
    logic                 w_last;
    t_cell_job            n_job;
    logic signed [CW-1:0] w_x, w_y, w_z;
    logic signed [CW-1:0] w_vx [4];
    logic signed [CW-1:0] w_vy [4];
    logic signed [CW-1:0] w_vz [4];

    assign o_stall     = r_job_valid && i_job_stall;
    assign w_acc       = i_valid && !o_stall;
    assign w_last      = i_data.vertex_index == (i_data.is_tetrahedron ? 2'd3 : 2'd2);
    assign w_x         = i_data.x[CW-1:0];
    assign w_y         = i_data.y[CW-1:0];
    assign w_z         = i_data.z[CW-1:0];
    assign o_job_valid = r_job_valid;
    assign o_job       = r_job;

    // Merge the incoming vertex with the stored ones
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_vx[k] = (i_data.vertex_index == 2'(k)) ? w_x : r_sx[k];
            w_vy[k] = (i_data.vertex_index == 2'(k)) ? w_y : r_sy[k];
            w_vz[k] = (i_data.vertex_index == 2'(k)) ? w_z : r_sz[k];
        end
    end

    // Form edge vectors
    always_comb begin
        n_job     = '0;
        n_job.tet = i_data.is_tetrahedron;
        n_job.f00 = DIF_BITS'(w_vx[1]) - DIF_BITS'(w_vx[0]);
        n_job.f01 = DIF_BITS'(w_vx[2]) - DIF_BITS'(w_vx[0]);
        n_job.f10 = DIF_BITS'(w_vy[1]) - DIF_BITS'(w_vy[0]);
        n_job.f11 = DIF_BITS'(w_vy[2]) - DIF_BITS'(w_vy[0]);
        if (i_data.is_tetrahedron) begin
            n_job.f02 = DIF_BITS'(w_vx[3]) - DIF_BITS'(w_vx[0]);
            n_job.f12 = DIF_BITS'(w_vy[3]) - DIF_BITS'(w_vy[0]);
            n_job.f20 = DIF_BITS'(w_vz[1]) - DIF_BITS'(w_vz[0]);
            n_job.f21 = DIF_BITS'(w_vz[2]) - DIF_BITS'(w_vz[0]);
            n_job.f22 = DIF_BITS'(w_vz[3]) - DIF_BITS'(w_vz[0]);
        end else begin
            n_job.f22 = DIF_BITS'(65536);
        end
    end

    // Store vertex
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_sx[i_data.vertex_index] <= w_x;
            r_sy[i_data.vertex_index] <= w_y;
            r_sz[i_data.vertex_index] <= w_z;
        end
    end

    // Hand off the cell job
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
        end else if (!o_stall) begin
            r_job_valid <= w_acc && w_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && w_last) begin
            r_job <= n_job;
        end
    end

endmodule

@@ rtl/acji_queue.sv @@
// Two-entry queue between front and back.
module acji_queue
    import acji_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_cell_job i_data,
    output logic      o_valid,
    input  logic      i_stall,
    output t_cell_job o_data
);

    t_cell_job  r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;

    assign o_stall = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_data  = r_mem[r_rp];
    assign w_push  = i_valid && !o_stall;
    assign w_pop   = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // Advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= !r_wp;
            if (w_pop) r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

endmodule

@@ rtl/acji_div.sv @@
// Restoring divider: one quotient bit per cycle, unsigned.
module acji_div
    import acji_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [DIV_BITS-1:0]  i_num,
    input  logic [DET_BITS-1:0]  i_den,
    output logic                 o_done,
    output logic [DIV_BITS-1:0]  o_quot
);

    localparam int CNT_BITS = $clog2(DIV_BITS + 1);

    logic [DIV_BITS-1:0] r_q;
    logic [DET_BITS:0]   r_rem;
    logic [DET_BITS-1:0] r_den;
    logic [CNT_BITS-1:0] r_cnt;
    logic                r_busy;
    logic [DET_BITS:0]   w_sh;
    logic                w_ge;

    assign w_sh   = {r_rem[DET_BITS-1:0], r_q[DIV_BITS-1]};
    assign w_ge   = w_sh >= {1'b0, r_den};
    assign o_done = r_busy && r_cnt == '0;
    assign o_quot = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_BITS'(DIV_BITS);
        end else if (r_busy) begin
            if (r_cnt == '0) r_busy <= 1'b0;
            else r_cnt <= r_cnt - CNT_BITS'(1);
        end
    end

    // Shift and subtract
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy && r_cnt != '0) begin
            r_rem <= w_ge ? w_sh - {1'b0, r_den} : w_sh;
            r_q   <= {r_q[DIV_BITS-2:0], w_ge};
        end
    end

endmodule

@@ rtl/acji_back.sv @@
// Back end: cofactors, determinant and scaled inverse through a shared divider.
module acji_back
    import acji_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [15:0] i_thresh,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_cell_job   i_job,
    output logic        o_valid,
    input  logic        i_stall,
    output t_out_item   o_data
);

    t_back_state r_state, n_state;
    t_cell_job   r_job;
    logic signed [DIF_BITS-1:0] r_f [9];
    logic signed [COF_BITS-1:0] r_c [9];
    logic signed [DET_BITS-1:0] r_det;
    logic        [DET_BITS-1:0] r_mag;
    logic                       r_sing;
    logic [3:0]                 r_idx;
    logic                       r_phase;
    logic                       r_div_go;
    logic signed [PRD_BITS-1:0] r_p0, r_p1;
    logic signed [31:0]         r_inv [9];
    logic                       r_ovalid;
    t_out_item                  r_out;

    logic w_take, w_done, w_sing, w_load_out, w_div_next;
    logic [DIV_BITS-1:0] w_quot;
    logic signed [DIF_BITS-1:0] w_a, w_b, w_c2, w_d;
    logic signed [DIF_BITS-1:0] w_fk;
    logic signed [COF_BITS-1:0] w_ck;
    logic signed [OPD_BITS-1:0] w_cop;
    logic [3:0]                 w_krow;
    logic signed [COF_BITS-1:0] w_num;
    logic [COF_BITS-1:0]        w_nmag;
    logic                       w_neg;
    logic [DET_BITS-1:0]        w_q16;
    logic signed [31:0]         w_sat;
    logic [3:0]                 w_ci;
    logic [1:0]                 w_i, w_j, w_i1, w_i2, w_j1, w_j2;

    assign o_stall = r_state != S_IDLE;
    assign w_take  = i_valid && r_state == S_IDLE;
    assign w_q16   = r_mag >> 32;
    assign w_sing  = (r_mag == '0) || (w_q16 < DET_BITS'(i_thresh));

    function automatic logic [1:0] inc3(input logic [1:0] v);
        return (v == 2'd2) ? 2'd0 : v + 2'd1;
    endfunction

    // Row and column of entry r_idx
    always_comb begin
        case (r_idx)
            4'd0: begin w_i = 2'd0; w_j = 2'd0; end
            4'd1: begin w_i = 2'd0; w_j = 2'd1; end
            4'd2: begin w_i = 2'd0; w_j = 2'd2; end
            4'd3: begin w_i = 2'd1; w_j = 2'd0; end
            4'd4: begin w_i = 2'd1; w_j = 2'd1; end
            4'd5: begin w_i = 2'd1; w_j = 2'd2; end
            4'd6: begin w_i = 2'd2; w_j = 2'd0; end
            4'd7: begin w_i = 2'd2; w_j = 2'd1; end
            default: begin w_i = 2'd2; w_j = 2'd2; end
        endcase
    end

    // Cofactor operand select for entry r_idx (row i, col j)
    always_comb begin
        w_i1 = inc3(w_i);
        w_i2 = inc3(w_i1);
        w_j1 = inc3(w_j);
        w_j2 = inc3(w_j1);
        w_a  = r_f[4'(w_i1) * 4'd3 + 4'(w_j1)];
        w_b  = r_f[4'(w_i2) * 4'd3 + 4'(w_j2)];
        w_c2 = r_f[4'(w_i1) * 4'd3 + 4'(w_j2)];
        w_d  = r_f[4'(w_i2) * 4'd3 + 4'(w_j1)];
    end

    // Determinant operands: row k = r_idx[2:1], upper cofactor chunk then lower
    assign w_krow = 4'(r_idx[2:1]) * 4'd3;
    assign w_fk   = r_f[w_krow];
    assign w_ck   = r_c[w_krow];
    assign w_cop  = r_idx[0] ? $signed({1'b0, w_ck[LOW_BITS-1:0]})
                             : OPD_BITS'($signed(w_ck[COF_BITS-1:LOW_BITS]));

    // Divider numerator: cofactor c[j][i] for inverse entry (i, j)
    assign w_ci   = 4'(w_j) * 4'd3 + 4'(w_i);
    assign w_num  = r_c[w_ci];
    assign w_nmag = w_num[COF_BITS-1] ? COF_BITS'(-w_num) : COF_BITS'(w_num);
    assign w_neg  = w_num[COF_BITS-1] != r_det[DET_BITS-1];

    acji_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_div_go),
        .i_num  (DIV_BITS'(w_nmag) << 32),
        .i_den  (r_mag),
        .o_done (w_done),
        .o_quot (w_quot)
    );

    // Saturate signed quotient
    always_comb begin
        if (!w_neg) begin
            w_sat = (w_quot > DIV_BITS'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF
                                                        : 32'(w_quot);
        end else begin
            w_sat = (w_quot > DIV_BITS'(32'h8000_0000)) ? 32'sh8000_0000
                                                        : 32'(-w_quot);
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (w_take) n_state = S_COF;
            S_COF:  if (r_phase && r_idx == 4'd8) n_state = S_DET;
            S_DET:  if (r_phase && r_idx == 4'd5) n_state = S_MAG;
            S_MAG:  n_state = S_CHK;
            S_CHK:  n_state = w_sing ? S_OUT : S_DIV;
            S_DIV:  if (w_done && r_idx == 4'd8) n_state = S_OUT;
            S_OUT:  if (!r_ovalid || !i_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // State outputs: divider start and result load
    always_comb begin
        w_div_next = 1'b0;
        w_load_out = 1'b0;
        case (r_state)
            S_CHK:   w_div_next = !w_sing;
            S_DIV:   w_div_next = w_done && r_idx != 4'd8;
            S_OUT:   w_load_out = !r_ovalid || !i_stall;
            default: ;
        endcase
    end

    // Output register
    assign o_valid = r_ovalid;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_div_go <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_div_go <= w_div_next;
            if (w_load_out) r_ovalid <= 1'b1;
            else if (!i_stall) r_ovalid <= 1'b0;
        end
    end

    // Datapath sequencing
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_job   <= i_job;
                r_f[0]  <= i_job.f00; r_f[1] <= i_job.f01; r_f[2] <= i_job.f02;
                r_f[3]  <= i_job.f10; r_f[4] <= i_job.f11; r_f[5] <= i_job.f12;
                r_f[6]  <= i_job.f20; r_f[7] <= i_job.f21; r_f[8] <= i_job.f22;
                r_idx   <= 4'd0;
                r_phase <= 1'b0;
                r_det   <= '0;
            end
            S_COF: begin
                if (!r_phase) begin
                    r_p0 <= w_a * w_b;
                    r_p1 <= w_c2 * w_d;
                end else begin
                    r_c[r_idx] <= COF_BITS'(r_p0) - COF_BITS'(r_p1);
                    r_idx      <= (r_idx == 4'd8) ? 4'd0 : r_idx + 4'd1;
                end
                r_phase <= !r_phase;
            end
            S_DET: begin
                // Accumulate f[k][0] * c[k][0] over k, one cofactor chunk at a time
                if (!r_phase) begin
                    r_p0 <= w_fk * w_cop;
                end else begin
                    r_det <= r_det + (r_idx[0] ? DET_BITS'(r_p0)
                                               : DET_BITS'(r_p0) <<< LOW_BITS);
                    r_idx <= (r_idx == 4'd5) ? 4'd0 : r_idx + 4'd1;
                end
                r_phase <= !r_phase;
            end
            S_MAG: begin
                r_mag <= r_det[DET_BITS-1] ? DET_BITS'(-r_det) : DET_BITS'(r_det);
                r_idx <= 4'd0;
            end
            S_CHK: begin
                r_sing <= w_sing;
            end
            S_DIV: begin
                if (w_done) begin
                    r_inv[r_idx] <= (r_job.tet || (w_i != 2'd2 && w_j != 2'd2))
                                    ? w_sat : 32'sd0;
                    r_idx <= r_idx + 4'd1;
                end
            end
            S_OUT: begin
                if (!r_ovalid || !i_stall) begin
                    r_out.inv_00   <= r_sing ? '0 : r_inv[0];
                    r_out.inv_01   <= r_sing ? '0 : r_inv[1];
                    r_out.inv_02   <= r_sing ? '0 : r_inv[2];
                    r_out.inv_10   <= r_sing ? '0 : r_inv[3];
                    r_out.inv_11   <= r_sing ? '0 : r_inv[4];
                    r_out.inv_12   <= r_sing ? '0 : r_inv[5];
                    r_out.inv_20   <= r_sing ? '0 : r_inv[6];
                    r_out.inv_21   <= r_sing ? '0 : r_inv[7];
                    r_out.inv_22   <= r_sing ? '0 : r_inv[8];
                    r_out.abs_det  <= (w_q16 > DET_BITS'(48'hFFFF_FFFF_FFFF))
                                      ? 48'hFFFF_FFFF_FFFF : w_q16[47:0];
                    r_out.singular <= r_sing;
                end
            end
            default: ;
        endcase
    end

endmodule
